/* rtl/scf_pkg.sv */
package scf_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] CRC_POLY = 8'h91;

	localparam int PC_W = 4;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] channel;
		logic [13:0] value_a;
		logic [13:0] value_b;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic last_byte;
	} pkt_item_t;

	typedef enum logic [2:0] {
		ACT_TARGET = 3'd0,
		ACT_SPEED = 3'd1,
		ACT_ACCEL = 3'd2,
		ACT_PWM = 3'd3,
		ACT_HOME = 3'd4,
		ACT_GET_POS = 3'd5,
		ACT_GET_MOVING = 3'd6,
		ACT_GET_ERRORS = 3'd7
	} action_t;

	typedef enum logic [3:0] {
		SRC_HDR = 4'd0,
		SRC_DEV = 4'd1,
		SRC_CMD = 4'd2,
		SRC_CHAN = 4'd3,
		SRC_ALO = 4'd4,
		SRC_AHI = 4'd5,
		SRC_BLO = 4'd6,
		SRC_BHI = 4'd7,
		SRC_CRC = 4'd8
	} src_t;

	typedef enum logic [1:0] {
		OP_NEXT = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_DATA_END = 2'd2,
		OP_CRC_END = 2'd3
	} seq_op_t;

	typedef struct packed {
		src_t src;
		seq_op_t op;
	} ucode_t;

	typedef struct packed {
		logic emit;
		src_t src;
		logic last;
	} dp_ctl_t;

	localparam logic [PC_W-1:0] PC_START = 4'd0;
	localparam logic [PC_W-1:0] PC_CHAN_VAL = 4'd2;
	localparam logic [PC_W-1:0] PC_PWM = 4'd6;
	localparam logic [PC_W-1:0] PC_GET_POS = 4'd11;
	localparam logic [PC_W-1:0] PC_CMD_ONLY = 4'd13;
	localparam logic [PC_W-1:0] PC_CRC = 4'd14;

	function automatic logic [7:0] command_code(input logic [2:0] action);
		logic [7:0] code;
		unique case (action_t'(action))
			ACT_TARGET: code = 8'h04;
			ACT_SPEED: code = 8'h07;
			ACT_ACCEL: code = 8'h09;
			ACT_PWM: code = 8'h0A;
			ACT_HOME: code = 8'h22;
			ACT_GET_POS: code = 8'h10;
			ACT_GET_MOVING: code = 8'h13;
			ACT_GET_ERRORS: code = 8'h21;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] action);
		logic [PC_W-1:0] pc;
		unique case (action_t'(action))
			ACT_TARGET, ACT_SPEED, ACT_ACCEL: pc = PC_CHAN_VAL;
			ACT_PWM: pc = PC_PWM;
			ACT_GET_POS: pc = PC_GET_POS;
			ACT_HOME, ACT_GET_MOVING, ACT_GET_ERRORS: pc = PC_CMD_ONLY;
			default: pc = PC_CMD_ONLY;
		endcase
		return pc;
	endfunction

	function automatic logic [7:0] crc7_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = c ^ CRC_POLY;
			end
			c = c >> 1;
		end
		return c;
	endfunction

endpackage

/* rtl/scf_ucode_rom.sv */
module scf_ucode_rom
	import scf_pkg::*;
(
	input logic [PC_W-1:0] pc,
	output ucode_t word
);

	always_comb begin
		unique case (pc)
			4'd0: word = '{src: SRC_HDR, op: OP_NEXT};
			4'd1: word = '{src: SRC_DEV, op: OP_DISPATCH};
			4'd2: word = '{src: SRC_CMD, op: OP_NEXT};
			4'd3: word = '{src: SRC_CHAN, op: OP_NEXT};
			4'd4: word = '{src: SRC_ALO, op: OP_NEXT};
			4'd5: word = '{src: SRC_AHI, op: OP_DATA_END};
			4'd6: word = '{src: SRC_CMD, op: OP_NEXT};
			4'd7: word = '{src: SRC_ALO, op: OP_NEXT};
			4'd8: word = '{src: SRC_AHI, op: OP_NEXT};
			4'd9: word = '{src: SRC_BLO, op: OP_NEXT};
			4'd10: word = '{src: SRC_BHI, op: OP_DATA_END};
			4'd11: word = '{src: SRC_CMD, op: OP_NEXT};
			4'd12: word = '{src: SRC_CHAN, op: OP_DATA_END};
			4'd13: word = '{src: SRC_CMD, op: OP_DATA_END};
			4'd14: word = '{src: SRC_CRC, op: OP_CRC_END};
			default: word = '{src: SRC_CRC, op: OP_CRC_END};
		endcase
	end

endmodule

/* rtl/scf_sequencer.sv */
module scf_sequencer
	import scf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2:0] action,
	input logic crc_enable,
	input logic load_ok,
	output logic busy,
	output dp_ctl_t ctl
);

	logic busy_q;
	logic [PC_W-1:0] pc_q;
	logic [2:0] action_q;
	ucode_t word;
	logic [PC_W-1:0] pc_next;
	logic last;

	scf_ucode_rom u_rom (
		.pc(pc_q),
		.word(word)
	);

	always_comb begin
		pc_next = pc_q + 4'd1;
		last = 1'b0;
		unique case (word.op)
			OP_NEXT: pc_next = pc_q + 4'd1;
			OP_DISPATCH: pc_next = entry_pc(action_q);
			OP_DATA_END: begin
				pc_next = PC_CRC;
				last = ~crc_enable;
			end
			OP_CRC_END: begin
				pc_next = PC_START;
				last = 1'b1;
			end
			default: pc_next = PC_START;
		endcase
	end

	assign ctl.emit = busy_q & load_ok;
	assign ctl.src = word.src;
	assign ctl.last = last;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= PC_START;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q <= PC_START;
		end else if (ctl.emit) begin
			busy_q <= ~last;
			pc_q <= last ? PC_START : pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			action_q <= action;
		end
	end

endmodule

/* rtl/scf_datapath.sv */
module scf_datapath
	import scf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_item_t cmd,
	input logic [6:0] dev_id,
	input dp_ctl_t ctl,
	output logic load_ok,
	output logic pkt_valid,
	input logic pkt_stall,
	output pkt_item_t pkt
);

	cmd_item_t cmd_q;
	logic [7:0] crc_q;
	logic [7:0] byte_sel;
	logic out_valid_q;
	pkt_item_t out_q;

	always_comb begin
		unique case (ctl.src)
			SRC_HDR: byte_sel = HEADER_BYTE;
			SRC_DEV: byte_sel = {1'b0, dev_id};
			SRC_CMD: byte_sel = command_code(cmd_q.action);
			SRC_CHAN: byte_sel = {1'b0, cmd_q.channel};
			SRC_ALO: byte_sel = {1'b0, cmd_q.value_a[6:0]};
			SRC_AHI: byte_sel = {1'b0, cmd_q.value_a[13:7]};
			SRC_BLO: byte_sel = {1'b0, cmd_q.value_b[6:0]};
			SRC_BHI: byte_sel = {1'b0, cmd_q.value_b[13:7]};
			SRC_CRC: byte_sel = crc_q;
			default: byte_sel = crc_q;
		endcase
	end

	assign load_ok = ~out_valid_q | ~pkt_stall;
	assign pkt_valid = out_valid_q;
	assign pkt = out_q;

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
			crc_q <= 8'h00;
		end else if (ctl.emit) begin
			crc_q <= crc7_update(crc_q, byte_sel);
		end
		if (ctl.emit) begin
			out_q.tx_byte <= byte_sel;
			out_q.last_byte <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/servo_command_packet_framer.sv */
// Servo command packet framer.
// The cmd channel takes one command per transfer (action, channel, value_a,
// value_b). The pkt channel returns the packet one byte per transfer, with
// last_byte set on the final byte. A packet holds three to eight bytes.
// After the command transfer the sequencer starts and loads the header byte
// into the output register, and with no stall on pkt one byte follows every
// cycle. A small microcode program steps through the bytes, and cmd_stall
// stays high until the sequencer has loaded the last byte into the output
// register, so the next command can be taken once that byte is loaded.
// A stall on pkt holds the output register and pauses the sequencer; no byte
// is lost.
// The APB port holds the device ID at address 0 and crc_enable at address 4;
// write them only while no packet is in flight.
// Reset clears the sequencer and the output valid flag and sets
// the device ID to 12 and crc_enable to 0.
module servo_command_packet_framer
	import scf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input cmd_item_t cmd,
	output logic pkt_valid,
	input logic pkt_stall,
	output pkt_item_t pkt,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [6:0] dev_id_q;
	logic crc_enable_q;
	logic busy;
	logic start;
	logic load_ok;
	dp_ctl_t ctl;

	assign pready = 1'b1;
	assign cmd_stall = busy;
	assign start = cmd_valid & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q <= 7'd12;
			crc_enable_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				crc_enable_q <= pwdata[0];
			end else begin
				dev_id_q <= pwdata[6:0];
			end
		end
	end

	assign prdata = paddr[2] ? {31'd0, crc_enable_q} : {25'd0, dev_id_q};

	scf_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(cmd.action),
		.crc_enable(crc_enable_q),
		.load_ok(load_ok),
		.busy(busy),
		.ctl(ctl)
	);

	scf_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.dev_id(dev_id_q),
		.ctl(ctl),
		.load_ok(load_ok),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb
	import scf_pkg::*;
();

	localparam logic [2:0] ADDR_DEV_ID = 3'd0;
	localparam logic [2:0] ADDR_CRC_ENABLE = 3'd4;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_PER_PHASE = 70;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_item_t cmd = '0;
	logic pkt_valid;
	logic pkt_stall = 1'b0;
	pkt_item_t pkt;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [6:0] cfg_device = 7'd12;
	logic cfg_crc = 1'b0;
	pkt_item_t expected_bytes[$];
	int fail_count = 0;
	int idle_cycles = 0;

	bit tx_gaps = 1'b0;
	int burst_left = 0;
	bit rx_stalls = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int run_left = 0;
	bit run_stalled = 1'b0;

	servo_command_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt(pkt),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] opcode_for(input action_t act);
		case (act)
			ACT_TARGET: return 8'h04;
			ACT_SPEED: return 8'h07;
			ACT_ACCEL: return 8'h09;
			ACT_PWM: return 8'h0A;
			ACT_HOME: return 8'h22;
			ACT_GET_POS: return 8'h10;
			ACT_GET_MOVING: return 8'h13;
			default: return 8'h21;
		endcase
	endfunction

	function automatic logic [7:0] crc7_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ (CRC_POLY >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void predict_packet(input cmd_item_t c);
		logic [7:0] bytes[$];
		logic [7:0] crc;
		pkt_item_t p;
		bytes.push_back(HEADER_BYTE);
		bytes.push_back({1'b0, cfg_device});
		bytes.push_back(opcode_for(action_t'(c.action)));
		case (action_t'(c.action))
			ACT_TARGET, ACT_SPEED, ACT_ACCEL: begin
				bytes.push_back({1'b0, c.channel});
				bytes.push_back({1'b0, c.value_a[6:0]});
				bytes.push_back({1'b0, c.value_a[13:7]});
			end
			ACT_PWM: begin
				bytes.push_back({1'b0, c.value_a[6:0]});
				bytes.push_back({1'b0, c.value_a[13:7]});
				bytes.push_back({1'b0, c.value_b[6:0]});
				bytes.push_back({1'b0, c.value_b[13:7]});
			end
			ACT_GET_POS: begin
				bytes.push_back({1'b0, c.channel});
			end
			default: begin
			end
		endcase
		if (cfg_crc) begin
			crc = 8'h00;
			foreach (bytes[i]) crc = crc7_step(crc, bytes[i]);
			bytes.push_back(crc);
		end
		foreach (bytes[i]) begin
			p.tx_byte = bytes[i];
			p.last_byte = (i == bytes.size() - 1);
			expected_bytes.push_back(p);
		end
	endfunction

	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		c.action = 3'($urandom);
		c.channel = 7'($urandom);
		c.value_a = 14'($urandom);
		c.value_b = 14'($urandom);
		return c;
	endfunction

	task automatic send_cmd(input cmd_item_t c);
		@(negedge clk);
		if (tx_gaps && burst_left == 0) begin
			cmd_valid <= 1'b0;
			cmd <= random_cmd();
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		predict_packet(c);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
		logic [31:0] got;
		apb_transfer(1'b0, addr, 32'h0, got);
		if (got !== want) begin
			$error("register %0d readback: expected %h, actual %h", addr, want, got);
			fail_count++;
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		logic [31:0] unused;
		apb_transfer(1'b1, addr, data, unused);
		case (addr)
			ADDR_DEV_ID: cfg_device = data[6:0];
			ADDR_CRC_ENABLE: cfg_crc = data[0];
			default: begin
			end
		endcase
		check_reg(addr, data);
	endtask

	task automatic set_config(input logic [6:0] dev, input logic crc_on);
		write_reg(ADDR_DEV_ID, {25'b0, dev});
		write_reg(ADDR_CRC_ENABLE, {31'b0, crc_on});
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pkt_stall <= 1'b1;
		end else if (!rx_stalls) begin
			pkt_stall <= 1'b0;
		end else begin
			if (run_left == 0) begin
				run_stalled = !run_stalled;
				run_left = run_stalled ? $urandom_range(1, 4) : $urandom_range(1, 8);
			end
			run_left--;
			pkt_stall <= run_stalled;
		end
	end

	always @(posedge clk) begin : check_pkt
		pkt_item_t want;
		if (arst_n && pkt_valid && !pkt_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected transfer: tx_byte %h, last_byte %b", pkt.tx_byte,
					pkt.last_byte);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (pkt.tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %h, actual %h", want.tx_byte, pkt.tx_byte);
					fail_count++;
				end
				if (pkt.last_byte !== want.last_byte) begin
					$error("last_byte: expected %b, actual %b", want.last_byte,
						pkt.last_byte);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_stall === 1'b0) || (pkt_valid && !pkt_stall) ||
				(psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("servo_command_packet_framer verification failed");
			$finish;
		end
	end

	task automatic test_reset_values();
		check_reg(ADDR_DEV_ID, 32'd12);
		check_reg(ADDR_CRC_ENABLE, 32'd0);
		for (int a = 0; a < 4; a++) send_cmd(random_cmd());
		wait_for_drain();
	endtask

	task automatic test_directed_commands();
		cmd_item_t c;
		set_config(7'd0, 1'b1);
		for (int a = 0; a < 8; a++) begin
			c.action = action_t'(a);
			c.channel = 7'h7F;
			c.value_a = 14'h3FFF;
			c.value_b = 14'h3FFF;
			send_cmd(c);
		end
		wait_for_drain();
		set_config(7'd127, 1'b0);
		for (int a = 0; a < 8; a++) begin
			c.action = action_t'(a);
			c.channel = 7'h00;
			c.value_a = 14'h0000;
			c.value_b = 14'h0000;
			send_cmd(c);
		end
		c = '{action: ACT_PWM, channel: 7'h55, value_a: 14'h2AAA, value_b: 14'h1555};
		send_cmd(c);
		c = '{action: ACT_TARGET, channel: 7'h2A, value_a: 14'h007F, value_b: 14'h3F80};
		send_cmd(c);
		c = '{action: ACT_SPEED, channel: 7'h01, value_a: 14'h3F80, value_b: 14'h007F};
		send_cmd(c);
		wait_for_drain();
	endtask

	task automatic test_input_backpressure();
		set_config(7'h5A, 1'b1);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		repeat (24) send_cmd(random_cmd());
		wait_for_drain();
	endtask

	task automatic test_random_phases();
		logic [6:0] dev;
		logic crc_on;
		for (int p = 0; p < 6; p++) begin
			dev = 7'($urandom);
			crc_on = p[0];
			tx_gaps = 1'b1;
			rx_stalls = 1'b1;
			case (p)
				0: begin
					dev = 7'd127;
					crc_on = 1'b1;
				end
				1: begin
					dev = 7'd0;
					tx_gaps = 1'b0;
					rx_stalls = 1'b0;
				end
				2: rx_stalls = 1'b0;
				3: tx_gaps = 1'b0;
				default: begin
				end
			endcase
			set_config(dev, crc_on);
			repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
			wait_for_drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_commands();
		test_input_backpressure();
		test_random_phases();
		wait_for_drain();
		if (fail_count == 0) begin
			$display("servo_command_packet_framer verification clean");
		end else begin
			$display("servo_command_packet_framer verification failed");
		end
		$finish;
	end

endmodule
